FILE: hdl/afdc_pkg.sv
// shared types, byte codes and frame-kind codes for the api frame deframer
// no dependencies
package afdc_pkg;

   localparam logic [7:0] ESC_BYTE      = 8'h7D;
   localparam logic [7:0] ESC_XOR       = 8'h20;
   localparam logic [7:0] START_BYTE    = 8'h7E;

   localparam logic [7:0] TYPE_RX       = 8'h90;
   localparam logic [7:0] TYPE_IOSAMPLE = 8'h92;
   localparam logic [7:0] TYPE_ATRESP   = 8'h88;
   localparam logic [7:0] TYPE_TXSTATUS = 8'h8B;

   localparam logic [7:0] SUB_ADDNODE   = 8'h02;
   localparam logic [7:0] SUB_MASK      = 8'h04;
   localparam logic [7:0] SUB_NODEFREQ  = 8'h06;
   localparam logic [7:0] SUB_FREQ      = 8'h08;
   localparam logic [7:0] SUB_IO        = 8'h0A;

   localparam int unsigned IDX_W = 17;

   localparam logic [IDX_W-1:0] IDX_LEN_MSB = 17'd1;
   localparam logic [IDX_W-1:0] IDX_LEN_LSB = 17'd2;
   localparam logic [IDX_W-1:0] IDX_TYPE    = 17'd3;
   localparam logic [IDX_W-1:0] IDX_SUBTYPE = 17'd15;
   localparam logic [IDX_W-1:0] HDR_BYTES   = 17'd3;

   typedef enum logic [3:0] {
      KIND_UNKNOWN     = 4'd0,
      KIND_ADDNODE     = 4'd1,
      KIND_MASK        = 4'd2,
      KIND_NODEFREQ    = 4'd3,
      KIND_FREQ        = 4'd4,
      KIND_IO          = 4'd5,
      KIND_TXSTATUS    = 4'd6,
      KIND_IOSAMPLE    = 4'd7,
      KIND_ATRESP      = 4'd8,
      KIND_BAD_SUBTYPE = 4'd9
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEN_MSB,
      PH_LEN_LSB,
      PH_BODY
   } phase_type;

   // unescaped byte or abort marker handed from front to back
   typedef struct packed {
      logic       abort;
      logic [7:0] data;
   } token_type;

   function automatic kind_type classify(input logic [7:0] ftype,
                                         input logic [7:0] subtype,
                                         input logic       seen);
      kind_type k;
      k = KIND_UNKNOWN;
      unique case (ftype)
         TYPE_RX: begin
            if (!seen) begin
               k = KIND_BAD_SUBTYPE;
            end else begin
               unique case (subtype)
                  SUB_ADDNODE:  k = KIND_ADDNODE;
                  SUB_MASK:     k = KIND_MASK;
                  SUB_NODEFREQ: k = KIND_NODEFREQ;
                  SUB_FREQ:     k = KIND_FREQ;
                  SUB_IO:       k = KIND_IO;
                  default:      k = KIND_BAD_SUBTYPE;
               endcase
            end
         end
         TYPE_TXSTATUS: k = KIND_TXSTATUS;
         TYPE_IOSAMPLE: k = KIND_IOSAMPLE;
         TYPE_ATRESP:   k = KIND_ATRESP;
         default:       k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

FILE: hdl/afdc_front.sv
// front end: takes raw link bytes, strips escapes, forwards tokens to the queue
// depends on afdc_pkg
module afdc_front
   import afdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   input  logic       req_link_abort,
   output logic       req_full,
   input  logic       q_full,
   output logic       q_push,
   output token_type  q_token
);

   logic accept;
   logic esc_pending_ff;
   logic esc_pending_in;

   assign accept   = req_push & ~q_full;
   assign req_full = q_full;

   always_comb begin
      q_push         = 1'b0;
      q_token.abort  = req_link_abort;
      q_token.data   = req_rx_byte;
      esc_pending_in = esc_pending_ff;
      if (accept) begin
         if (req_link_abort) begin
            q_push         = 1'b1;
            esc_pending_in = 1'b0;
         end else if (esc_pending_ff) begin
            q_token.data   = req_rx_byte ^ ESC_XOR;
            q_push         = 1'b1;
            esc_pending_in = 1'b0;
         end else if (req_rx_byte == ESC_BYTE) begin
            esc_pending_in = 1'b1;
         end else begin
            q_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_pending_ff <= 1'b0;
      end else begin
         esc_pending_ff <= esc_pending_in;
      end
   end

endmodule

FILE: hdl/afdc_fifo.sv
// short register queue of tokens between front and back
// depends on afdc_pkg
module afdc_fifo
   import afdc_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   output logic      full,
   input  logic      pop,
   output token_type head,
   output logic      empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   token_type         slot_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

FILE: hdl/afdc_back.sv
// back end: frame parser, byte indexing, classification and result register
// depends on afdc_pkg
module afdc_back
   import afdc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  token_type        q_token,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_frame_byte,
   output logic [IDX_W-1:0] rsp_byte_index,
   output logic             rsp_last_of_frame,
   output logic [3:0]       rsp_frame_kind
);

   phase_type        phase_ff, phase_in;
   logic [15:0]      body_len_ff, body_len_in;
   logic [IDX_W-1:0] position_ff, position_in;
   logic [7:0]       ftype_ff, ftype_in;
   logic [7:0]       subtype_ff, subtype_in;
   logic             seen_ff, seen_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic             rsp_last_ff;
   kind_type         rsp_kind_ff;

   logic             advance;
   logic             emit;
   logic [IDX_W-1:0] idx;
   logic             last;
   kind_type         kind;
   logic             at_type, at_subtype;
   logic [7:0]       eff_type, eff_subtype;
   logic             eff_seen;

   // a token is queued and the result slot is free or being drained this cycle
   assign advance = ~q_empty & (~rsp_valid_ff | rsp_pop);
   assign q_pop   = advance;

   // type/subtype written on this very byte must count for the classification
   assign at_type     = (position_ff == IDX_TYPE);
   assign at_subtype  = (position_ff == IDX_SUBTYPE);
   assign eff_type    = at_type ? q_token.data : ftype_ff;
   assign eff_subtype = at_subtype ? q_token.data : subtype_ff;
   assign eff_seen    = at_subtype | seen_ff;

   // outputs of the parser
   always_comb begin
      emit = 1'b0;
      idx  = '0;
      last = 1'b0;
      kind = KIND_UNKNOWN;
      if (advance && !q_token.abort) begin
         unique case (phase_ff)
            PH_IDLE: begin
               emit = (q_token.data == START_BYTE);
            end
            PH_LEN_MSB: begin
               emit = 1'b1;
               idx  = IDX_LEN_MSB;
            end
            PH_LEN_LSB: begin
               emit = 1'b1;
               idx  = IDX_LEN_LSB;
            end
            PH_BODY: begin
               emit = 1'b1;
               idx  = position_ff;
               last = (position_ff >= ({1'b0, body_len_ff} + HDR_BYTES));
               if (last) begin
                  kind = classify(eff_type, eff_subtype, eff_seen);
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   // next state of the parser
   always_comb begin
      phase_in    = phase_ff;
      body_len_in = body_len_ff;
      position_in = position_ff;
      ftype_in    = ftype_ff;
      subtype_in  = subtype_ff;
      seen_in     = seen_ff;
      if (advance) begin
         if (q_token.abort) begin
            phase_in = PH_IDLE;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (q_token.data == START_BYTE) begin
                     phase_in    = PH_LEN_MSB;
                     position_in = IDX_LEN_MSB;
                     ftype_in    = '0;
                     subtype_in  = '0;
                     seen_in     = 1'b0;
                  end
               end
               PH_LEN_MSB: begin
                  phase_in    = PH_LEN_LSB;
                  body_len_in = {q_token.data, 8'h00};
                  position_in = IDX_LEN_LSB;
               end
               PH_LEN_LSB: begin
                  phase_in    = PH_BODY;
                  body_len_in = {body_len_ff[15:8], q_token.data};
                  position_in = HDR_BYTES;
               end
               PH_BODY: begin
                  ftype_in    = eff_type;
                  subtype_in  = eff_subtype;
                  seen_in     = eff_seen;
                  position_in = position_ff + 1'b1;
                  if (last) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         body_len_ff  <= '0;
         position_ff  <= '0;
         ftype_ff     <= '0;
         subtype_ff   <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         body_len_ff  <= body_len_in;
         position_ff  <= position_in;
         ftype_ff     <= ftype_in;
         subtype_ff   <= subtype_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_byte_ff <= q_token.data;
         rsp_idx_ff  <= idx;
         rsp_last_ff <= last;
         rsp_kind_ff <= kind;
      end
   end

   assign rsp_empty         = ~rsp_valid_ff;
   assign rsp_frame_byte    = rsp_byte_ff;
   assign rsp_byte_index    = rsp_idx_ff;
   assign rsp_last_of_frame = rsp_last_ff;
   assign rsp_frame_kind    = rsp_kind_ff;

endmodule

FILE: hdl/api_frame_deframer_classifier.sv
// top level of the escaped api frame receiver and classifier
// depends on afdc_pkg, afdc_front, afdc_fifo, afdc_back
//
//   channel   handshake          payload
//   request   req_push/req_full  req_rx_byte[7:0], req_link_abort
//   result    rsp_pop/rsp_empty  rsp_frame_byte[7:0], rsp_byte_index[16:0],
//                                rsp_last_of_frame, rsp_frame_kind[3:0]
//
// one raw byte per cycle is taken; the front strips escapes in the cycle of acceptance
// and the back parses one queued byte per cycle into a single result register
// a result passes from the token queue into the result register before it is on the outputs
// a stalled result holds the back; the token queue (QUEUE_DEPTH) then fills and raises req_full
// reset (synchronous) empties the queue and returns the parser to hunting for a start byte
module api_frame_deframer_classifier
   import afdc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_link_abort,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_frame_byte,
   output logic [16:0] rsp_byte_index,
   output logic        rsp_last_of_frame,
   output logic [3:0]  rsp_frame_kind
);

   logic      q_push, q_full, q_pop, q_empty;
   token_type q_in_token, q_head;

   afdc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_rx_byte    (req_rx_byte),
      .req_link_abort (req_link_abort),
      .req_full       (req_full),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_token        (q_in_token)
   );

   afdc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (q_in_token),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   afdc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_token           (q_head),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_frame_kind    (rsp_frame_kind)
   );

endmodule
